[rtl/cpl_pkg.sv]
// Package of the C punctuator lexer: token kinds, prefix states and decode functions.
`timescale 1ns / 1ps

package cpl_pkg;

	typedef logic [5:0] kind_t;
	typedef logic [1:0] len_t;

	// Token kinds, numbered as in the punctuator list.
	localparam kind_t K_NONE     = 6'd0;
	localparam kind_t K_NE       = 6'd1;
	localparam kind_t K_NOT      = 6'd2;
	localparam kind_t K_HASHHASH = 6'd3;
	localparam kind_t K_HASH     = 6'd4;
	localparam kind_t K_MODEQ    = 6'd5;
	localparam kind_t K_MOD      = 6'd6;
	localparam kind_t K_ANDAND   = 6'd7;
	localparam kind_t K_ANDEQ    = 6'd8;
	localparam kind_t K_AND      = 6'd9;
	localparam kind_t K_LPAREN   = 6'd10;
	localparam kind_t K_RPAREN   = 6'd11;
	localparam kind_t K_MULEQ    = 6'd12;
	localparam kind_t K_MUL      = 6'd13;
	localparam kind_t K_INC      = 6'd14;
	localparam kind_t K_ADDEQ    = 6'd15;
	localparam kind_t K_ADD      = 6'd16;
	localparam kind_t K_COMMA    = 6'd17;
	localparam kind_t K_DEC      = 6'd18;
	localparam kind_t K_SUBEQ    = 6'd19;
	localparam kind_t K_ARROW    = 6'd20;
	localparam kind_t K_SUB      = 6'd21;
	localparam kind_t K_ELLIPSIS = 6'd22;
	localparam kind_t K_DOT      = 6'd23;
	localparam kind_t K_DIVEQ    = 6'd24;
	localparam kind_t K_DIV      = 6'd25;
	localparam kind_t K_COLON    = 6'd26;
	localparam kind_t K_SEMI     = 6'd27;
	localparam kind_t K_SHLEQ    = 6'd28;
	localparam kind_t K_SHL      = 6'd29;
	localparam kind_t K_LE       = 6'd30;
	localparam kind_t K_LT       = 6'd31;
	localparam kind_t K_EQEQ     = 6'd32;
	localparam kind_t K_ASSIGN   = 6'd33;
	localparam kind_t K_SHREQ    = 6'd34;
	localparam kind_t K_SHR      = 6'd35;
	localparam kind_t K_GE       = 6'd36;
	localparam kind_t K_GT       = 6'd37;
	localparam kind_t K_QUEST    = 6'd38;
	localparam kind_t K_AT       = 6'd39;
	localparam kind_t K_LBRACK   = 6'd40;
	localparam kind_t K_BSLASH   = 6'd41;
	localparam kind_t K_RBRACK   = 6'd42;
	localparam kind_t K_XOREQ    = 6'd43;
	localparam kind_t K_XOR      = 6'd44;
	localparam kind_t K_LBRACE   = 6'd45;
	localparam kind_t K_OREQ     = 6'd46;
	localparam kind_t K_OROR     = 6'd47;
	localparam kind_t K_OR       = 6'd48;
	localparam kind_t K_RBRACE   = 6'd49;
	localparam kind_t K_TILDE    = 6'd50;

	// Pending prefix held between bytes.
	typedef enum logic [4:0] {
		P_IDLE, P_BANG, P_HASH, P_PERCENT, P_AMP, P_STAR, P_PLUS, P_MINUS, P_DOT,
		P_DOTDOT, P_SLASH, P_LT, P_SHL, P_EQ, P_GT, P_SHR, P_CARET, P_BAR
	} prefix_t;

	// Outcome of one byte: done = token finished, grow = longer prefix held.
	typedef struct packed {
		logic    done;
		logic    grow;
		prefix_t nxt;
		kind_t   kind;
	} dec_t;

	function automatic dec_t finish(kind_t k);
		dec_t d;
		d = '{done: 1'b1, grow: 1'b0, nxt: P_IDLE, kind: k};
		return d;
	endfunction

	function automatic dec_t hold(prefix_t p);
		dec_t d;
		d = '{done: 1'b0, grow: 1'b1, nxt: p, kind: K_NONE};
		return d;
	endfunction

	function automatic dec_t start_of(logic [7:0] c);
		dec_t d;
		case (c)
			"!":  d = hold(P_BANG);
			"#":  d = hold(P_HASH);
			"%":  d = hold(P_PERCENT);
			"&":  d = hold(P_AMP);
			"*":  d = hold(P_STAR);
			"+":  d = hold(P_PLUS);
			"-":  d = hold(P_MINUS);
			".":  d = hold(P_DOT);
			"/":  d = hold(P_SLASH);
			"<":  d = hold(P_LT);
			"=":  d = hold(P_EQ);
			">":  d = hold(P_GT);
			"^":  d = hold(P_CARET);
			"|":  d = hold(P_BAR);
			"(":  d = finish(K_LPAREN);
			")":  d = finish(K_RPAREN);
			",":  d = finish(K_COMMA);
			":":  d = finish(K_COLON);
			";":  d = finish(K_SEMI);
			"?":  d = finish(K_QUEST);
			"@":  d = finish(K_AT);
			"[":  d = finish(K_LBRACK);
			"\\": d = finish(K_BSLASH);
			"]":  d = finish(K_RBRACK);
			"{":  d = finish(K_LBRACE);
			"}":  d = finish(K_RBRACE);
			"~":  d = finish(K_TILDE);
			default: d = finish(K_NONE);
		endcase
		return d;
	endfunction

	// Neither done nor grow means the byte cannot extend the prefix.
	function automatic dec_t extend_of(prefix_t p, logic [7:0] c);
		dec_t d;
		d = '{done: 1'b0, grow: 1'b0, nxt: P_IDLE, kind: K_NONE};
		unique case (p)
			P_BANG:    if (c == "=") d = finish(K_NE);
			P_HASH:    if (c == "#") d = finish(K_HASHHASH);
			P_PERCENT: if (c == "=") d = finish(K_MODEQ);
			P_AMP: begin
				if (c == "&") d = finish(K_ANDAND);
				else if (c == "=") d = finish(K_ANDEQ);
			end
			P_STAR:    if (c == "=") d = finish(K_MULEQ);
			P_PLUS: begin
				if (c == "+") d = finish(K_INC);
				else if (c == "=") d = finish(K_ADDEQ);
			end
			P_MINUS: begin
				if (c == "-") d = finish(K_DEC);
				else if (c == "=") d = finish(K_SUBEQ);
				else if (c == ">") d = finish(K_ARROW);
			end
			P_DOT:     if (c == ".") d = hold(P_DOTDOT);
			P_DOTDOT:  if (c == ".") d = finish(K_ELLIPSIS);
			P_SLASH:   if (c == "=") d = finish(K_DIVEQ);
			P_LT: begin
				if (c == "<") d = hold(P_SHL);
				else if (c == "=") d = finish(K_LE);
			end
			P_SHL:     if (c == "=") d = finish(K_SHLEQ);
			P_EQ:      if (c == "=") d = finish(K_EQEQ);
			P_GT: begin
				if (c == ">") d = hold(P_SHR);
				else if (c == "=") d = finish(K_GE);
			end
			P_SHR:     if (c == "=") d = finish(K_SHREQ);
			P_CARET:   if (c == "=") d = finish(K_XOREQ);
			P_BAR: begin
				if (c == "=") d = finish(K_OREQ);
				else if (c == "|") d = finish(K_OROR);
			end
			default: d = '{done: 1'b0, grow: 1'b0, nxt: P_IDLE, kind: K_NONE};
		endcase
		return d;
	endfunction

	function automatic kind_t lone_kind(prefix_t p);
		kind_t k;
		unique case (p)
			P_BANG:    k = K_NOT;
			P_HASH:    k = K_HASH;
			P_PERCENT: k = K_MOD;
			P_AMP:     k = K_AND;
			P_STAR:    k = K_MUL;
			P_PLUS:    k = K_ADD;
			P_MINUS:   k = K_SUB;
			P_DOT:     k = K_DOT;
			P_SLASH:   k = K_DIV;
			P_LT:      k = K_LT;
			P_SHL:     k = K_SHL;
			P_EQ:      k = K_ASSIGN;
			P_GT:      k = K_GT;
			P_SHR:     k = K_SHR;
			P_CARET:   k = K_XOR;
			P_BAR:     k = K_OR;
			default:   k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic len_t lone_len(prefix_t p);
		len_t l;
		case (p)
			P_IDLE:                 l = 2'd0;
			P_DOTDOT, P_SHL, P_SHR: l = 2'd2;
			default:                l = 2'd1;
		endcase
		return l;
	endfunction

endpackage

[rtl/cpl_in_if.sv]
// Input channel of the C punctuator lexer: one source character per item.
`timescale 1ns / 1ps

interface cpl_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  byte_in;
	logic        end_of_input;
	logic        column_load;
	logic [15:0] column_value;

	modport source (output valid, byte_in, end_of_input, column_load, column_value,
		input ready);
	modport sink (input valid, byte_in, end_of_input, column_load, column_value,
		output ready);
endinterface

[rtl/cpl_out_if.sv]
// Output channel of the C punctuator lexer: one token per item.
`timescale 1ns / 1ps

interface cpl_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  token_kind;
	logic [1:0]  token_length;
	logic        error_flag;
	logic        byte_returned;
	logic [15:0] start_column;
	logic [7:0]  text_byte;

	modport source (output valid, token_kind, token_length, error_flag, byte_returned,
		start_column, text_byte, input ready);
	modport sink (input valid, token_kind, token_length, error_flag, byte_returned,
		start_column, text_byte, output ready);
endinterface

[rtl/c_punctuator_lexer.sv]
// Top level of the C punctuator lexer.
// The block splits a character stream into C punctuators by longest match of up to three
// characters. Each item on chr is one byte, an end-of-input marker or a column load; an
// item on tok is one finished token with its kind (1 to 50, 0 when unrecognised), length,
// start column and error flag. When a byte cannot extend the pending prefix, the prefix is
// closed as a token with byte_returned set and the byte is not consumed: the sender must
// submit that same byte again. The block accepts one item per clock cycle unless stalled
// as described below. The item is caught in the input register when it is accepted and
// is decoded from there into the result register, from which a finished token is offered
// on tok. The rate is set by the update of the prefix and column registers for each item.
// A full result register that is not taken stalls the input side only when the waiting
// item would itself produce a token.
`timescale 1ns / 1ps

module c_punctuator_lexer #(
	parameter int COLUMN_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	cpl_in_if.sink        chr,
	cpl_out_if.source     tok
);
	import cpl_pkg::*;

	// Input register
	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   eoi_s1;
	logic                   load_s1;
	logic [15:0]            colval_s1;

	// Lexer state
	prefix_t                prefix_q;
	logic [COLUMN_BITS-1:0] col_q;
	logic [COLUMN_BITS-1:0] start_q;

	// Result register
	logic                   out_valid_q;
	kind_t                  kind_q;
	len_t                   len_q;
	logic                   ret_q;
	logic [15:0]            scol_q;
	logic [7:0]             text_q;

	// Decode of the item in the input register
	dec_t                   dec;
	logic                   emit;
	kind_t                  emit_kind;
	len_t                   emit_len;
	logic                   emit_ret;
	logic [COLUMN_BITS-1:0] emit_start;
	logic [7:0]             emit_text;
	prefix_t                prefix_d;
	logic [COLUMN_BITS-1:0] col_d;
	logic [COLUMN_BITS-1:0] start_d;
	logic                   advance;

	logic [COLUMN_BITS+15:0] load_ext;
	logic [COLUMN_BITS+15:0] scol_ext;

	// Column load value fitted to the counter width, and the start column fitted to the
	// 16-bit output field, whichever way round the widths lie.
	assign load_ext = {{COLUMN_BITS{1'b0}}, colval_s1};
	assign scol_ext = {16'd0, emit_start};

	always_comb begin
		dec        = start_of(byte_s1);
		emit       = 1'b0;
		emit_kind  = K_NONE;
		emit_len   = 2'd1;
		emit_ret   = 1'b0;
		emit_start = start_q;
		emit_text  = 8'd0;
		prefix_d   = prefix_q;
		col_d      = col_q;
		start_d    = start_q;
		if (load_s1) begin
			// A pending prefix survives a column load together with its start column.
			col_d = load_ext[COLUMN_BITS-1:0];
		end else if (eoi_s1) begin
			if (prefix_q != P_IDLE) begin
				emit      = 1'b1;
				emit_kind = lone_kind(prefix_q);
				emit_len  = lone_len(prefix_q);
				prefix_d  = P_IDLE;
			end
		end else if (prefix_q == P_IDLE) begin
			col_d = col_q + COLUMN_BITS'(1);
			if (dec.grow) begin
				prefix_d = dec.nxt;
				start_d  = col_q;
			end else begin
				emit       = 1'b1;
				emit_kind  = dec.kind;
				emit_start = col_q;
				// Only an unrecognised character echoes its byte.
				emit_text  = (dec.kind == K_NONE) ? byte_s1 : 8'd0;
			end
		end else begin
			dec = extend_of(prefix_q, byte_s1);
			if (!dec.done && !dec.grow) begin
				// The byte closes the prefix without being consumed.
				emit      = 1'b1;
				emit_kind = lone_kind(prefix_q);
				emit_len  = lone_len(prefix_q);
				emit_ret  = 1'b1;
				prefix_d  = P_IDLE;
			end else begin
				col_d = col_q + COLUMN_BITS'(1);
				if (dec.grow) begin
					prefix_d = dec.nxt;
				end else begin
					emit      = 1'b1;
					emit_kind = dec.kind;
					emit_len  = lone_len(prefix_q) + 2'd1;
					prefix_d  = P_IDLE;
				end
			end
		end
	end

	// The held item moves on unless it makes a token and the result register is blocked.
	assign advance   = valid_s1 && (!emit || !out_valid_q || tok.ready);
	assign chr.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chr.ready) begin
			valid_s1 <= chr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chr.valid && chr.ready) begin
			byte_s1   <= chr.byte_in;
			eoi_s1    <= chr.end_of_input;
			load_s1   <= chr.column_load;
			colval_s1 <= chr.column_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= P_IDLE;
			col_q    <= '0;
			start_q  <= '0;
		end else if (advance) begin
			prefix_q <= prefix_d;
			col_q    <= col_d;
			start_q  <= start_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (tok.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q <= emit_kind;
			len_q  <= emit_len;
			ret_q  <= emit_ret;
			scol_q <= scol_ext[15:0];
			text_q <= emit_text;
		end
	end

	assign tok.valid         = out_valid_q;
	assign tok.token_kind    = kind_q;
	assign tok.token_length  = len_q;
	assign tok.error_flag    = (kind_q == K_NONE) || (kind_q == K_AT);
	assign tok.byte_returned = ret_q;
	assign tok.start_column  = scol_q;
	assign tok.text_byte     = text_q;

	// A held item that cannot move on stays in the input register unchanged.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(eoi_s1)
			&& $stable(load_s1)))
		else $error("input register changed while stalled");

	// Only the three-character punctuators have length three.
	a_len3: assert property (@(posedge clk) disable iff (!arst_n)
		(tok.valid && tok.token_length == 2'd3) |->
			(tok.token_kind == K_ELLIPSIS || tok.token_kind == K_SHLEQ
			|| tok.token_kind == K_SHREQ))
		else $error("length three on a short punctuator");

	// An echoed byte belongs to a one-character unrecognised token.
	a_text: assert property (@(posedge clk) disable iff (!arst_n)
		(tok.valid && tok.text_byte != 8'd0) |->
			(tok.token_kind == K_NONE && tok.token_length == 2'd1 && !tok.byte_returned))
		else $error("text byte on a recognised token");

	// Without a load, the column moves by at most one per item.
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !load_s1) |=>
			(col_q == $past(col_q) || col_q == $past(col_q) + COLUMN_BITS'(1)))
		else $error("column counter jumped");

endmodule

[dv/c_punctuator_lexer_tb.sv]
// Testbench of the C punctuator lexer: random and directed byte streams checked token by token.
`timescale 1ns / 1ps

module c_punctuator_lexer_tb;

	import cpl_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned STREAM_ITEMS = 1450;

	// One token as the output channel carries it.
	typedef struct packed {
		kind_t       kind;
		len_t        len;
		logic        err;
		logic        ret;
		logic [15:0] col;
		logic [7:0]  text;
	} token_t;

	logic clk = 1'b0;
	logic arst_n;

	cpl_in_if  chr ();
	cpl_out_if tok ();

	c_punctuator_lexer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chr    (chr),
		.tok    (tok)
	);

	always #2 clk = ~clk;

	// Tokens still owed by the block, oldest first.
	token_t expected_tokens[$];
	token_t oldest_token;

	// Our own copy of the lexer state: held prefix, column of the next byte and
	// column at which the held prefix began.
	prefix_t     held    = P_IDLE;
	logic [15:0] col_next = '0;
	logic [15:0] tok_col  = '0;

	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned items_sent     = 0;
	int unsigned tx_max_gap     = 9;
	int unsigned rx_max_gap     = 9;
	int unsigned holdoff_cycles = 0;
	bit          last_returned  = 1'b0;
	bit          allow_drop     = 1'b0;

	// Spellings of all fifty punctuators, used to build well-formed streams.
	string spellings[50] = '{
		"!=", "!", "##", "#", "%=", "%", "&&", "&=", "&", "(", ")", "*=", "*", "++", "+=",
		"+", ",", "--", "-=", "->", "-", "...", ".", "/=", "/", ":", ";", "<<=", "<<", "<=",
		"<", "==", "=", ">>=", ">>", ">=", ">", "?", "@", "[", "\\", "]", "^=", "^", "{",
		"|=", "||", "|", "}", "~"
	};

	// Every token is an error when its kind is unrecognised or it is the at sign.
	function automatic token_t token_of(kind_t kind, len_t len, logic ret,
			logic [15:0] col, logic [7:0] text);
		token_t t;
		t = '{kind: kind, len: len, err: (kind == K_NONE) || (kind == K_AT), ret: ret,
			col: col, text: text};
		return t;
	endfunction

	// The token that a held prefix stands for when nothing extends it. The double
	// dot on its own has no kind of its own and comes out as an error of length two.
	function automatic token_t lone_token(prefix_t p, logic ret, logic [15:0] col);
		kind_t kind;
		len_t  len;
		len = 2'd1;
		case (p)
			P_BANG:    kind = K_NOT;
			P_HASH:    kind = K_HASH;
			P_PERCENT: kind = K_MOD;
			P_AMP:     kind = K_AND;
			P_STAR:    kind = K_MUL;
			P_PLUS:    kind = K_ADD;
			P_MINUS:   kind = K_SUB;
			P_DOT:     kind = K_DOT;
			P_SLASH:   kind = K_DIV;
			P_LT:      kind = K_LT;
			P_EQ:      kind = K_ASSIGN;
			P_GT:      kind = K_GT;
			P_CARET:   kind = K_XOR;
			P_BAR:     kind = K_OR;
			P_SHL: begin
				kind = K_SHL;
				len  = 2'd2;
			end
			P_SHR: begin
				kind = K_SHR;
				len  = 2'd2;
			end
			default: begin
				kind = K_NONE;
				len  = 2'd2;
			end
		endcase
		return token_of(kind, len, ret, col, 8'h00);
	endfunction

	// Advances the lexer copy by one accepted item. Returns 1 when the item
	// finishes a token, which is then given in t.
	function automatic bit munch_step(input logic [7:0] c, input logic eoi, input logic load,
			input logic [15:0] value, output token_t t);
		prefix_t grow_to;
		kind_t   done_kind;
		token_t  lone;
		t         = '0;
		grow_to   = P_IDLE;
		done_kind = K_NONE;

		// A column load wins over everything else and leaves a held prefix alone.
		if (load) begin
			col_next = value;
			return 1'b0;
		end

		// End of input flushes a held prefix; when idle it does nothing.
		if (eoi) begin
			if (held == P_IDLE)
				return 1'b0;
			t    = lone_token(held, 1'b0, tok_col);
			held = P_IDLE;
			return 1'b1;
		end

		if (held == P_IDLE) begin
			case (c)
				"!":  grow_to = P_BANG;
				"#":  grow_to = P_HASH;
				"%":  grow_to = P_PERCENT;
				"&":  grow_to = P_AMP;
				"*":  grow_to = P_STAR;
				"+":  grow_to = P_PLUS;
				"-":  grow_to = P_MINUS;
				".":  grow_to = P_DOT;
				"/":  grow_to = P_SLASH;
				"<":  grow_to = P_LT;
				"=":  grow_to = P_EQ;
				">":  grow_to = P_GT;
				"^":  grow_to = P_CARET;
				"|":  grow_to = P_BAR;
				"(":  done_kind = K_LPAREN;
				")":  done_kind = K_RPAREN;
				",":  done_kind = K_COMMA;
				":":  done_kind = K_COLON;
				";":  done_kind = K_SEMI;
				"?":  done_kind = K_QUEST;
				"@":  done_kind = K_AT;
				"[":  done_kind = K_LBRACK;
				"\\": done_kind = K_BSLASH;
				"]":  done_kind = K_RBRACK;
				"{":  done_kind = K_LBRACE;
				"}":  done_kind = K_RBRACE;
				"~":  done_kind = K_TILDE;
				default: done_kind = K_NONE;
			endcase
			if (grow_to != P_IDLE) begin
				held     = grow_to;
				tok_col  = col_next;
				col_next = col_next + 16'd1;
				return 1'b0;
			end
			// Single-character token; an unknown byte is echoed back in text.
			t = token_of(done_kind, 2'd1, 1'b0, col_next, done_kind == K_NONE ? c : 8'h00);
			col_next = col_next + 16'd1;
			return 1'b1;
		end

		case (held)
			P_BANG:    if (c == "=") done_kind = K_NE;
			P_HASH:    if (c == "#") done_kind = K_HASHHASH;
			P_PERCENT: if (c == "=") done_kind = K_MODEQ;
			P_AMP: begin
				if (c == "&") done_kind = K_ANDAND;
				else if (c == "=") done_kind = K_ANDEQ;
			end
			P_STAR:    if (c == "=") done_kind = K_MULEQ;
			P_PLUS: begin
				if (c == "+") done_kind = K_INC;
				else if (c == "=") done_kind = K_ADDEQ;
			end
			P_MINUS: begin
				if (c == "-") done_kind = K_DEC;
				else if (c == "=") done_kind = K_SUBEQ;
				else if (c == ">") done_kind = K_ARROW;
			end
			P_DOT:     if (c == ".") grow_to = P_DOTDOT;
			P_DOTDOT:  if (c == ".") done_kind = K_ELLIPSIS;
			P_SLASH:   if (c == "=") done_kind = K_DIVEQ;
			P_LT: begin
				if (c == "<") grow_to = P_SHL;
				else if (c == "=") done_kind = K_LE;
			end
			P_SHL:     if (c == "=") done_kind = K_SHLEQ;
			P_EQ:      if (c == "=") done_kind = K_EQEQ;
			P_GT: begin
				if (c == ">") grow_to = P_SHR;
				else if (c == "=") done_kind = K_GE;
			end
			P_SHR:     if (c == "=") done_kind = K_SHREQ;
			P_CARET:   if (c == "=") done_kind = K_XOREQ;
			P_BAR: begin
				if (c == "=") done_kind = K_OREQ;
				else if (c == "|") done_kind = K_OROR;
			end
			default: ;
		endcase

		// The byte cannot extend the prefix: close it and hand the byte back.
		if (grow_to == P_IDLE && done_kind == K_NONE) begin
			t    = lone_token(held, 1'b1, tok_col);
			held = P_IDLE;
			return 1'b1;
		end

		col_next = col_next + 16'd1;
		if (grow_to != P_IDLE) begin
			held = grow_to;
			return 1'b0;
		end
		lone = lone_token(held, 1'b0, tok_col);
		t    = token_of(done_kind, lone.len + 2'd1, 1'b0, tok_col, 8'h00);
		held = P_IDLE;
		return 1'b1;
	endfunction

	// Offers one item after a random gap and waits for it to be taken. Inputs change
	// on the falling edge only; valid stays high across back-to-back items.
	task automatic send_item(input logic [7:0] c, input logic eoi, input logic load,
			input logic [15:0] value);
		int unsigned gap;
		token_t      t;
		bit          has_token;
		gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
		repeat (gap) begin
			@(negedge clk);
			chr.valid = 1'b0;
		end
		@(negedge clk);
		chr.valid        = 1'b1;
		chr.byte_in      = c;
		chr.end_of_input = eoi;
		chr.column_load  = load;
		chr.column_value = value;
		do
			@(posedge clk);
		while (!chr.ready);
		has_token = munch_step(c, eoi, load, value, t);
		if (has_token)
			expected_tokens.push_back(t);
		last_returned = has_token && t.ret;
		items_sent++;
	endtask

	// Sends one character and, as a well-behaved caller does, sends it again when
	// the block hands it back. Now and then the random part leaves that out.
	task automatic send_char(input logic [7:0] c);
		send_item(c, 1'b0, 1'b0, 16'($urandom));
		if (last_returned && !(allow_drop && $urandom_range(0, 31) == 0))
			send_item(c, 1'b0, 1'b0, 16'($urandom));
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// Drops valid and waits until every owed token has come back.
	task automatic wait_drained();
		@(negedge clk);
		chr.valid = 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
	endtask

	// One random step of a source stream: mostly punctuators, with unknown bytes,
	// stray double dots, end markers and column loads mixed in.
	task automatic random_item();
		int unsigned pick;
		logic [15:0] value;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0:       value = 16'h0000;
			1:       value = 16'hFFFF;
			default: value = 16'($urandom);
		endcase
		if (pick < 68)
			send_text(spellings[$urandom_range(0, 49)]);
		else if (pick < 80)
			send_char(8'($urandom_range(0, 255)));
		else if (pick < 85)
			send_text("..");
		else if (pick < 91)
			send_item(8'($urandom), 1'b1, 1'b0, 16'($urandom));
		else if (pick < 97)
			send_item(8'($urandom), 1'b0, 1'b1, value);
		else
			send_item(8'($urandom), 1'b1, 1'b1, value);
	endtask

	// Extremes of the fields and each corner of the munch rules in a short stream.
	task automatic test_directed();
		allow_drop = 1'b0;
		// Start near the top of the column range so the counter wraps mid-token.
		send_item(8'h00, 1'b0, 1'b1, 16'hFFFE);
		send_text("<<=");
		// A shift that cannot grow further hands back the letter after it.
		send_text(">>x");
		// A lone double dot is an error of length two; three dots are an ellipsis.
		send_text("..,");
		send_text("...");
		send_char(8'h00);
		send_char(8'hFF);
		send_char("@");
		// End of input flushes a held minus, then does nothing while idle.
		send_char("-");
		send_item(8'hA5, 1'b1, 1'b0, 16'h0000);
		send_item(8'h5A, 1'b1, 1'b0, 16'hFFFF);
		// A column load keeps the held prefix and its start column.
		send_char("!");
		send_item(8'hFF, 1'b0, 1'b1, 16'h0000);
		send_char("=");
		// Load and end of input together: the load wins and the dot stays held.
		send_char(".");
		send_item(8'h2E, 1'b1, 1'b1, 16'h1234);
		send_item(8'h00, 1'b1, 1'b0, 16'h0000);
		send_char(8'h80);
	endtask

	// Back-to-back items on both sides with no idling at all.
	task automatic test_full_rate();
		int unsigned stop_at;
		allow_drop = 1'b1;
		tx_max_gap = 0;
		rx_max_gap = 0;
		stop_at    = items_sent + 150;
		while (items_sent < stop_at)
			random_item();
		tx_max_gap = 9;
		rx_max_gap = 9;
	endtask

	// The result side holds off for a long stretch while items keep coming, so the
	// result register fills and the input side must stall; afterwards the sender
	// waits until every token has come out.
	task automatic test_result_holdoff();
		int unsigned stop_at;
		tx_max_gap     = 0;
		holdoff_cycles = 300;
		stop_at        = items_sent + 80;
		while (items_sent < stop_at)
			random_item();
		tx_max_gap = 9;
		wait_drained();
	endtask

	// Long random stream, with the idling of each side changed every hundred items.
	task automatic test_random_stream();
		int unsigned next_change;
		allow_drop  = 1'b1;
		next_change = items_sent;
		while (items_sent < STREAM_ITEMS) begin
			if (items_sent >= next_change) begin
				tx_max_gap  = ($urandom_range(0, 2) == 0) ? 0 : 9;
				rx_max_gap  = ($urandom_range(0, 2) == 0) ? 0 : 9;
				next_change = items_sent + 100;
			end
			random_item();
		end
	endtask

	// Result taker: draws a stall for each token, or takes a long hold-off when
	// one has been asked for.
	initial begin
		int unsigned stall;
		tok.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (holdoff_cycles != 0) begin
				stall          = holdoff_cycles;
				holdoff_cycles = 0;
			end else begin
				stall = (rx_max_gap == 0) ? 0 : $urandom_range(0, rx_max_gap);
			end
			if (stall != 0) begin
				@(negedge clk);
				tok.ready = 1'b0;
				repeat (stall - 1)
					@(negedge clk);
			end
			@(negedge clk);
			tok.ready = 1'b1;
			do
				@(posedge clk);
			while (!tok.valid);
		end
	end

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Every token taken is compared with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && tok.valid && tok.ready) begin
			if (expected_tokens.size() == 0) begin
				$display("%0t: token with none owed, expected nothing, actual kind %0d col %0h",
					$time, tok.token_kind, tok.start_column);
				mismatch_count++;
			end else begin
				oldest_token = expected_tokens.pop_front();
				check_field("token_kind", 16'(oldest_token.kind), 16'(tok.token_kind));
				check_field("token_length", 16'(oldest_token.len), 16'(tok.token_length));
				check_field("error_flag", 16'(oldest_token.err), 16'(tok.error_flag));
				check_field("byte_returned", 16'(oldest_token.ret), 16'(tok.byte_returned));
				check_field("start_column", oldest_token.col, tok.start_column);
				check_field("text_byte", 16'(oldest_token.text), 16'(tok.text_byte));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("c_punctuator_lexer_tb failed");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		chr.valid        = 1'b0;
		chr.byte_in      = 8'h00;
		chr.end_of_input = 1'b0;
		chr.column_load  = 1'b0;
		chr.column_value = 16'h0000;
		repeat (12)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_rate();
		test_result_holdoff();
		test_random_stream();

		wait_drained();
		repeat (10)
			@(posedge clk);
		if (mismatch_count == 0)
			$display("c_punctuator_lexer_tb passed");
		else
			$display("c_punctuator_lexer_tb failed");
		$finish;
	end

endmodule
